[design/tcjl_pkg.sv]
// package: shared widths and polynomial coefficient tables for the linearizer
`timescale 1ns / 1ps
`default_nettype none
package tcjl_pkg;

  localparam int ADC_BITS = 10;
  localparam int GAIN_W   = 24;
  localparam int PROD_W   = ADC_BITS + GAIN_W;
  localparam int VM_W     = PROD_W - 16;
  localparam int T_W      = 26;
  localparam int HW       = 40;
  localparam int V_W      = 16;
  localparam int TEMP_W   = 17;

  // configuration register indexes
  localparam logic REG_TC_GAIN  = 1'b0;
  localparam logic REG_AMB_GAIN = 1'b1;

  localparam logic [T_W-1:0]    T_AMB_MAX = T_W'(760 * 65536);
  localparam logic [V_W-1:0]    V_MAX_UV  = V_W'(42919);
  localparam logic [TEMP_W-1:0] TEMP_MAX  = TEMP_W'(120000);

  // forward type j coefficients, c_k scaled by 2^(26+10(k-1))
  localparam logic signed [HW-1:0] FWD_COEF [0:8] = '{
    40'sd0,
    40'sd3381024282,
    40'sd2094283567,
    -40'sd6029268992,
    40'sd9531919267,
    -40'sd12582862077,
    40'sd15827929824,
    -40'sd9701113249,
    40'sd1238472904
  };

  // inverse coefficients, a_k scaled by 2^(38+16(k-1))
  localparam logic signed [HW-1:0] INV_COEF [0:7] = '{
    40'sd0,
    40'sd5438253230,
    -40'sd3605048635,
    40'sd12242369123,
    -40'sd19727247656,
    40'sd18178885410,
    -40'sd17759433099,
    40'sd11106576898
  };

endpackage
`default_nettype wire

[design/tcjl_fwd.sv]
// forward polynomial pipeline: ambient temperature to junction voltage
`timescale 1ns / 1ps
`default_nettype none
module tcjl_fwd import tcjl_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [T_W-1:0]         in_t,
  input  wire logic [VM_W-1:0]        in_vm,
  output logic                        out_valid,
  output logic [HW-1:0]               out_vt,
  output logic [VM_W-1:0]             out_vm
);

  localparam int PW = HW + T_W + 2;

  // per step: a multiply stage then a round/add stage
  logic                   mv_r  [0:7];
  logic signed [PW-1:0]   p_r   [0:7];
  logic [T_W-1:0]         mt_r  [0:7];
  logic [VM_W-1:0]        mvm_r [0:7];
  logic                   av_r  [0:7];
  logic signed [HW-1:0]   h_r   [0:7];
  logic [T_W-1:0]         at_r  [0:7];
  logic [VM_W-1:0]        avm_r [0:7];

  genvar j;
  generate
    for (j = 0; j < 8; j++) begin : g_step
      logic                 v_src;
      logic signed [HW-1:0] h_src;
      logic [T_W-1:0]       t_src;
      logic [VM_W-1:0]      vm_src;
      logic signed [PW-1:0] p_nxt;
      logic signed [PW-1:0] rs;
      logic signed [HW-1:0] h_nxt;

      if (j == 0) begin : g_first
        assign v_src  = in_valid;
        assign h_src  = FWD_COEF[8];
        assign t_src  = in_t;
        assign vm_src = in_vm;
      end else begin : g_next
        assign v_src  = av_r[j-1];
        assign h_src  = h_r[j-1];
        assign t_src  = at_r[j-1];
        assign vm_src = avm_r[j-1];
      end

      assign p_nxt = PW'(h_src) * $signed({2'b00, t_src});

      if (j < 7) begin : g_add
        assign rs    = (p_r[j] + (PW'(1) <<< 25)) >>> 26;
        assign h_nxt = FWD_COEF[7-j] + $signed(rs[HW-1:0]);
      end else begin : g_last
        // junction voltage in uv, negative taken as zero
        assign rs    = (p_r[j] + (PW'(1) <<< 41)) >>> 42;
        assign h_nxt = rs[PW-1] ? '0 : $signed(rs[HW-1:0]);
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          mv_r[j] <= 1'b0;
          av_r[j] <= 1'b0;
        end else if (en) begin
          mv_r[j] <= v_src;
          av_r[j] <= mv_r[j];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          p_r[j]   <= p_nxt;
          mt_r[j]  <= t_src;
          mvm_r[j] <= vm_src;
          h_r[j]   <= h_nxt;
          at_r[j]  <= mt_r[j];
          avm_r[j] <= mvm_r[j];
        end
      end
    end
  endgenerate

  assign out_valid = av_r[7];
  assign out_vt    = h_r[7];
  assign out_vm    = avm_r[7];

endmodule
`default_nettype wire

[design/tcjl_inv.sv]
// inverse polynomial pipeline: compensated voltage to temperature
`timescale 1ns / 1ps
`default_nettype none
module tcjl_inv import tcjl_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [V_W-1:0]       in_v,
  input  wire logic                 in_over,
  output logic                      out_valid,
  output logic [TEMP_W-1:0]         out_temp,
  output logic                      out_over
);

  localparam int PW = HW + V_W + 2;
  localparam int QW = PW + 8;

  logic                   mv_r [0:6];
  logic signed [PW-1:0]   p_r  [0:6];
  logic [V_W-1:0]         mvv_r[0:6];
  logic                   mo_r [0:6];
  logic                   av_r [0:5];
  logic signed [HW-1:0]   g_r  [0:5];
  logic [V_W-1:0]         avv_r[0:5];
  logic                   ao_r [0:5];

  genvar j;
  generate
    for (j = 0; j < 7; j++) begin : g_step
      logic                 v_src;
      logic signed [HW-1:0] g_src;
      logic [V_W-1:0]       vv_src;
      logic                 o_src;
      logic signed [PW-1:0] p_nxt;

      if (j == 0) begin : g_first
        assign v_src  = in_valid;
        assign g_src  = INV_COEF[7];
        assign vv_src = in_v;
        assign o_src  = in_over;
      end else begin : g_next
        assign v_src  = av_r[j-1];
        assign g_src  = g_r[j-1];
        assign vv_src = avv_r[j-1];
        assign o_src  = ao_r[j-1];
      end

      assign p_nxt = PW'(g_src) * $signed({2'b00, vv_src});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          mv_r[j] <= 1'b0;
        end else if (en) begin
          mv_r[j] <= v_src;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          p_r[j]   <= p_nxt;
          mvv_r[j] <= vv_src;
          mo_r[j]  <= o_src;
        end
      end

      if (j < 6) begin : g_add
        logic signed [PW-1:0] rs;
        assign rs = (p_r[j] + (PW'(1) <<< 15)) >>> 16;

        always_ff @(posedge clk) begin
          if (!rst_n) begin
            av_r[j] <= 1'b0;
          end else if (en) begin
            av_r[j] <= mv_r[j];
          end
        end

        always_ff @(posedge clk) begin
          if (en) begin
            g_r[j]   <= INV_COEF[6-j] + $signed(rs[HW-1:0]);
            avv_r[j] <= mvv_r[j];
            ao_r[j]  <= mo_r[j];
          end
        end
      end
    end
  endgenerate

  // times 100 as shift-add, then round and saturate
  logic                 sv_r;
  logic signed [QW-1:0] s_r;
  logic                 so_r;
  logic signed [QW-1:0] s_nxt;
  logic signed [QW-1:0] q;
  logic                 ov_r;
  logic [TEMP_W-1:0]    temp_r;
  logic                 oo_r;
  logic [TEMP_W-1:0]    temp_nxt;

  assign s_nxt = (QW'(p_r[6]) <<< 6) + (QW'(p_r[6]) <<< 5) + (QW'(p_r[6]) <<< 2);
  assign q     = (s_r + (QW'(1) <<< 37)) >>> 38;

  always_comb begin
    if (q[QW-1]) begin
      temp_nxt = '0;
    end else if (q > $signed(QW'(TEMP_MAX))) begin
      temp_nxt = TEMP_MAX;
    end else begin
      temp_nxt = q[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      sv_r <= mv_r[6];
      ov_r <= sv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= s_nxt;
      so_r   <= mo_r[6];
      temp_r <= temp_nxt;
      oo_r   <= so_r;
    end
  end

  assign out_valid = ov_r;
  assign out_temp  = temp_r;
  assign out_over  = oo_r;

endmodule
`default_nettype wire

[design/thermocouple_cold_junction_linearizer.sv]
// top level: type j thermocouple linearizer with cold-junction compensation
//
//   channel  ports                                   direction
//   in       in_valid/in_ready, tc_code, ambient     item in
//   out      out_valid/out_ready, temp_centi, over   item out
//   cfg      cfg_we, cfg_index, cfg_wdata            register write
//
// one item per cycle while the output is not stalled
// 35 register stages (input scaling 3, forward horner 16, voltage sum 1,
// inverse horner 15), the first loaded at the accepting edge
// the whole pipeline advances together; a stalled output freezes every stage
// synchronous active-low reset clears valid bits and restores both gains
`timescale 1ns / 1ps
`default_nettype none
module thermocouple_cold_junction_linearizer import tcjl_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ADC_BITS-1:0] in_tc_code,
  input  wire logic [ADC_BITS-1:0] in_ambient_code,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [TEMP_W-1:0]        out_temp_centi,
  output logic                     out_over_range,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [GAIN_W-1:0]   cfg_wdata
);

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic [GAIN_W-1:0] tc_gain_r;
  logic [GAIN_W-1:0] amb_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_gain_r  <= GAIN_W'(2310802);
      amb_gain_r <= GAIN_W'(35555);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TC_GAIN:  tc_gain_r  <= cfg_wdata;
        REG_AMB_GAIN: amb_gain_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // stage 1: codes, stage 2: products, stage 3: rounding and clamp
  logic                v1_r, v2_r, v3_r;
  logic [ADC_BITS-1:0] tc_r, amb_r;
  logic [PROD_W-1:0]   tcp_r, ambp_r;
  logic [VM_W-1:0]     vm_r;
  logic [T_W-1:0]      t_r;
  logic [PROD_W-1:0]   tcp_rnd;

  assign tcp_rnd = tcp_r + PROD_W'(32768);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tc_r   <= in_tc_code;
      amb_r  <= in_ambient_code;
      tcp_r  <= PROD_W'(tc_r) * PROD_W'(tc_gain_r);
      ambp_r <= PROD_W'(amb_r) * PROD_W'(amb_gain_r);
      vm_r   <= tcp_rnd[PROD_W-1:16];
      // ambient clamped to the top of the forward range
      t_r    <= (ambp_r > PROD_W'(T_AMB_MAX)) ? T_AMB_MAX : ambp_r[T_W-1:0];
    end
  end

  logic            fv;
  logic [HW-1:0]   fvt;
  logic [VM_W-1:0] fvm;

  tcjl_fwd u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_t      (t_r),
    .in_vm     (vm_r),
    .out_valid (fv),
    .out_vt    (fvt),
    .out_vm    (fvm)
  );

  // compensated voltage, limited to the top of the inverse range
  logic            sv_r;
  logic [V_W-1:0]  v_r;
  logic            over_r;
  logic [HW:0]     vsum;
  logic            over_nxt;

  assign vsum     = (HW+1)'(fvm) + (HW+1)'(fvt);
  assign over_nxt = vsum > (HW+1)'(V_MAX_UV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else if (en) begin
      sv_r <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      over_r <= over_nxt;
      v_r    <= over_nxt ? V_MAX_UV : vsum[V_W-1:0];
    end
  end

  tcjl_inv u_inv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sv_r),
    .in_v      (v_r),
    .in_over   (over_r),
    .out_valid (out_valid),
    .out_temp  (out_temp_centi),
    .out_over  (out_over_range)
  );

endmodule
`default_nettype wire

[bench/tb_thermocouple_cold_junction_linearizer.sv]
// testbench: linearizer checked item by item against an integer predictor
`timescale 1ns / 1ps
module tb_thermocouple_cold_junction_linearizer;
  import tcjl_pkg::*;

  localparam logic [GAIN_W-1:0] TC_GAIN_RST  = 24'd2310802;
  localparam logic [GAIN_W-1:0] AMB_GAIN_RST = 24'd35555;
  localparam longint TEMP_CEIL  = 120000;
  localparam longint V_CEIL     = 42919;
  localparam longint AMB_CEIL   = 760 * 65536;
  localparam int     STALL_MAX  = 18;
  localparam int     DRAIN_WAIT = 40;
  localparam int     WATCHDOG   = 3000;

  typedef struct packed {
    logic [TEMP_W-1:0] temp_centi;
    logic              over_range;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ADC_BITS-1:0] in_tc_code = '0;
  logic [ADC_BITS-1:0] in_ambient_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [TEMP_W-1:0] out_temp_centi;
  logic out_over_range;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [GAIN_W-1:0] cfg_wdata = '0;

  logic [GAIN_W-1:0] tc_gain_m  = TC_GAIN_RST;
  logic [GAIN_W-1:0] amb_gain_m = AMB_GAIN_RST;
  reading_t expected_readings[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  no_gaps = 1'b0;
  int  ready_hold = 0;

  thermocouple_cold_junction_linearizer dut (.*);

  always #10 clk = ~clk;

  function automatic longint rnd(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic reading_t linearize(logic [ADC_BITS-1:0] tc, logic [ADC_BITS-1:0] amb);
    longint vm, t, h, vt, v, ve, g, tp;
    reading_t r;
    vm = (longint'(tc) * longint'(tc_gain_m) + 32768) >>> 16;
    t = longint'(amb) * longint'(amb_gain_m);
    if (t > AMB_CEIL) t = AMB_CEIL;
    h = longint'(FWD_COEF[8]);
    for (int k = 7; k >= 1; k--) h = longint'(FWD_COEF[k]) + rnd(h * t, 26);
    vt = rnd(h * t, 42);
    if (vt < 0) vt = 0;
    v = vm + vt;
    r.over_range = (v > V_CEIL);
    ve = r.over_range ? V_CEIL : v;
    g = longint'(INV_COEF[7]);
    for (int k = 6; k >= 1; k--) g = longint'(INV_COEF[k]) + rnd(g * ve, 16);
    tp = rnd(g * ve * 100, 38);
    if (tp < 0) tp = 0;
    if (tp > TEMP_CEIL) tp = TEMP_CEIL;
    r.temp_centi = TEMP_W'(tp);
    return r;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    reading_t exp_r;
    int hold;
    if (rst_n) begin
      hold = ready_hold;
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected item temp=%0d over=%0b", $time, out_temp_centi,
                   out_over_range);
          errors++;
        end else begin
          exp_r = expected_readings.pop_front();
          if (out_temp_centi !== exp_r.temp_centi) begin
            $display("%0t: temp_centi expected %0d actual %0d", $time, exp_r.temp_centi,
                     out_temp_centi);
            errors++;
          end
          if (out_over_range !== exp_r.over_range) begin
            $display("%0t: over_range expected %0b actual %0b", $time, exp_r.over_range,
                     out_over_range);
            errors++;
          end
        end
        hold = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
      end else if (hold > 0) begin
        hold--;
      end
      ready_hold <= hold;
      out_ready <= (hold == 0);
    end
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("thermocouple_cold_junction_linearizer verification failed");
      $finish;
    end
  end

  task automatic send_reading(logic [ADC_BITS-1:0] tc, logic [ADC_BITS-1:0] amb);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tc_code <= tc;
    in_ambient_code <= amb;
    expected_readings.push_back(linearize(tc, amb));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_gain(logic idx, logic [GAIN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TC_GAIN) tc_gain_m = val;
    else amb_gain_m = val;
  endtask

  task automatic test_code_extremes;
    logic [ADC_BITS-1:0] corners[6] = '{10'd0, 10'd1, 10'd341, 10'd682, 10'd512, 10'd1023};
    foreach (corners[i]) send_reading(corners[i], corners[5 - i]);
    send_reading(10'd0, 10'd0);
    send_reading(10'd1023, 10'd1023);
    send_reading(10'd16, 10'd20);
    send_reading(10'd300, 10'd0);
    drain();
  endtask

  task automatic test_gain_extremes;
    // zero gains give zero voltage; max gains hit the ambient clamp and over-range
    write_gain(REG_TC_GAIN, '0);
    write_gain(REG_AMB_GAIN, '0);
    send_reading(10'd1023, 10'd1023);
    send_reading(10'd0, 10'd0);
    drain();
    write_gain(REG_TC_GAIN, '1);
    write_gain(REG_AMB_GAIN, '1);
    send_reading(10'd1023, 10'd1023);
    send_reading(10'd0, 10'd1);
    send_reading(10'd1, 10'd0);
    drain();
    // voltage just around the over-range threshold
    write_gain(REG_TC_GAIN, 24'd65536 * 42);
    write_gain(REG_AMB_GAIN, '0);
    for (int c = 1020; c <= 1023; c++) send_reading(ADC_BITS'(c), 10'd0);
    drain();
    write_gain(REG_TC_GAIN, 24'd2812412);
    send_reading(10'd1000, 10'd0);
    send_reading(10'd1001, 10'd0);
    drain();
  endtask

  task automatic test_random_phase(int count);
    logic [ADC_BITS-1:0] tc, amb;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      tc = $urandom_range(0, 1023);
      amb = $urandom_range(0, 1023);
      if ($urandom_range(0, 9) == 0) tc = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 9) == 0) amb = $urandom_range(0, 1) ? '1 : '0;
      send_reading(tc, amb);
    end
    no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_random_gains;
    write_gain(REG_TC_GAIN, TC_GAIN_RST);
    write_gain(REG_AMB_GAIN, AMB_GAIN_RST);
    test_random_phase(250);
    for (int p = 0; p < 6; p++) begin
      write_gain(REG_TC_GAIN, (p == 0) ? '1 : GAIN_W'($urandom_range(0, 4000000)));
      write_gain(REG_AMB_GAIN, (p == 1) ? '1 : GAIN_W'($urandom_range(0, 120000)));
      test_random_phase(100);
    end
    write_gain(REG_TC_GAIN, GAIN_W'($urandom));
    write_gain(REG_AMB_GAIN, GAIN_W'($urandom));
    test_random_phase(50);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_code_extremes();
    test_gain_extremes();
    test_random_gains();
    if (errors == 0) begin
      $display("thermocouple_cold_junction_linearizer verification clean");
    end else begin
      $display("thermocouple_cold_junction_linearizer verification failed");
    end
    $finish;
  end

endmodule
